// File: hw/rtl/sjfq_pkg.sv
// Shared types and constants for the shortest-job-first queue.
// Used by sjfq_cell, shortest_job_first_queue_top and sjfq_checker; no dependencies.
`timescale 1ns / 1ps

package sjfq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_W       = 16;
  localparam int ID_W        = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int COUNT_W     = 5;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 32;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic             insert;
    logic             remove;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/shortest_job_first_queue_top.sv
// Top level of the shortest-job-first queue: request decode, occupancy count,
// cell chain and result register. Depends on sjfq_pkg and sjfq_cell.
//
//  channel | dir | tdata (low bit up)                                | tuser
//  s_axis  | in  | job_len[15:0], job_id[23:16]                      | req_type
//  m_axis  | out | out_job_id[7:0], out_job_len[23:8],               | status[1:0]
//          |     | entry_count[28:24], zero[31:29]                   |
//
// One request per cycle while results are taken; each result is registered and appears in the cycle after its transfer.
// The single compare in each cell against the broadcast key sets the cycle.
// A stalled result holds in the output register and blocks new requests.
// Reset empties the queue at once; no clearing pass.
`timescale 1ns / 1ps

module shortest_job_first_queue_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [sjfq_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,  // job_len, job_id
  input  logic                                s_axis_tuser_i,  // req_type
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [sjfq_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,  // out_job_id, out_job_len,
                                                               // entry_count
  output logic [sjfq_pkg::STATUS_W-1:0]       m_axis_tuser_o   // status
);

  localparam int D = sjfq_pkg::QUEUE_DEPTH;

  logic [sjfq_pkg::CNT_W-1:0] count_q, count_d;
  logic                       out_valid_q;
  sjfq_pkg::status_e          status_q, status_d;
  sjfq_pkg::entry_t           result_q, result_d;
  logic [sjfq_pkg::COUNT_W-1:0] out_count_q;
  logic [sjfq_pkg::CNT_W+sjfq_pkg::COUNT_W-1:0] count_ext;

  logic                       accept;
  logic                       is_full, is_empty;
  sjfq_pkg::cell_ctrl_t       ctrl;
  sjfq_pkg::entry_t           entries [D];
  logic [D-1:0]               moves;
  logic [D-1:0]               valid;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_full         = (count_q == sjfq_pkg::CNT_W'(D));
  assign is_empty        = (count_q == '0);

  always_comb begin
    ctrl.key    = s_axis_tdata_i[sjfq_pkg::KEY_W-1:0];
    ctrl.id     = s_axis_tdata_i[sjfq_pkg::KEY_W +: sjfq_pkg::ID_W];
    ctrl.insert = accept && (s_axis_tuser_i == sjfq_pkg::REQ_ENQ) && !is_full;
    ctrl.remove = accept && (s_axis_tuser_i == sjfq_pkg::REQ_DEQ) && !is_empty;
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    assign valid[i] = (count_q > sjfq_pkg::CNT_W'(i));
    if (i == 0) begin : g_head
      sjfq_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .valid_i     (valid[i]),
        .left_i      ('0),
        .left_moves_i(1'b0),
        .right_i     (entries[i+1]),
        .entry_o     (entries[i]),
        .moves_o     (moves[i])
      );
    end else if (i == D - 1) begin : g_tail
      sjfq_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .valid_i     (valid[i]),
        .left_i      (entries[i-1]),
        .left_moves_i(moves[i-1]),
        .right_i     (entries[i]),
        .entry_o     (entries[i]),
        .moves_o     (moves[i])
      );
    end else begin : g_mid
      sjfq_cell u_cell (
        .clk_i       (clk_i),
        .ctrl_i      (ctrl),
        .valid_i     (valid[i]),
        .left_i      (entries[i-1]),
        .left_moves_i(moves[i-1]),
        .right_i     (entries[i+1]),
        .entry_o     (entries[i]),
        .moves_o     (moves[i])
      );
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = sjfq_pkg::STAT_OK;
    result_d = '0;
    if (s_axis_tuser_i == sjfq_pkg::REQ_ENQ) begin
      if (is_full) begin
        status_d = sjfq_pkg::STAT_FULL;
      end else begin
        count_d = count_q + sjfq_pkg::CNT_W'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = sjfq_pkg::STAT_EMPTY;
      end else begin
        result_d = entries[0];
        count_d  = count_q - sjfq_pkg::CNT_W'(1);
      end
    end
  end

  assign count_ext = {{sjfq_pkg::COUNT_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      result_q    <= result_d;
      out_count_q <= count_ext[sjfq_pkg::COUNT_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {3'b000, out_count_q, result_q.key, result_q.id};

endmodule

// File: hw/rtl/sjfq_cell.sv
// One slot of the sorted cell chain: holds a key and an id, shifts right on
// insert, left on remove. Depends on sjfq_pkg.
`timescale 1ns / 1ps

module sjfq_cell (
  input  logic                clk_i,
  input  sjfq_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  sjfq_pkg::entry_t    left_i,
  input  logic                left_moves_i,
  input  sjfq_pkg::entry_t    right_i,
  output sjfq_pkg::entry_t    entry_o,
  output logic                moves_o
);

  sjfq_pkg::entry_t entry_q, entry_d;

  // a slot moves right when it is empty or its key is above the new key
  assign moves_o = !valid_i || (ctrl_i.key < entry_q.key);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert && moves_o) begin
      if (left_moves_i) begin
        entry_d = left_i;
      end else begin
        entry_d.key = ctrl_i.key;
        entry_d.id  = ctrl_i.id;
      end
    end else if (ctrl_i.remove) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// File: hw/rtl/sjfq_checker.sv
// Port-level checks for shortest_job_first_queue_top, with its bind.
// Depends on sjfq_pkg.
`timescale 1ns / 1ps

module sjfq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [sjfq_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [sjfq_pkg::STATUS_W-1:0]   m_axis_tuser_o
);

  localparam logic [sjfq_pkg::COUNT_W-1:0] FULL_COUNT =
    sjfq_pkg::COUNT_W'(sjfq_pkg::QUEUE_DEPTH);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == sjfq_pkg::STAT_FULL) |->
      (m_axis_tdata_o[28:24] == FULL_COUNT) && (m_axis_tdata_o[23:0] == '0))
    else $error("dropped enqueue without a full queue");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == sjfq_pkg::STAT_EMPTY) |->
      (m_axis_tdata_o == '0))
    else $error("empty dequeue carries data");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[31:29] == 3'b000) &&
      ((m_axis_tuser_o == sjfq_pkg::STAT_OK) ||
       (m_axis_tuser_o == sjfq_pkg::STAT_EMPTY) ||
       (m_axis_tuser_o == sjfq_pkg::STAT_FULL)))
    else $error("bad padding or status code");

endmodule

bind shortest_job_first_queue_top sjfq_checker u_sjfq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
